// ===== rtl/core/dcsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcsg_pkg;

	// Phase and table geometry
	localparam int PHASE_BITS     = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int CODE_BITS      = 14;
	localparam int PH_W           = CODE_BITS + PHASE_BITS;
	localparam int QTR_BITS       = SINE_ADDR_BITS - 2;
	localparam int QTR_SIZE       = 1 << QTR_BITS;
	localparam int CARRIER_W      = 32;

	// code_rate alignment to the phase fraction
	localparam int RATE_SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
	localparam int RATE_SHR = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;

	// Configuration port
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 33;
	localparam int CODE_RATE_W = 33;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_RATE    = 3'd0,
		REG_CARRIER_STEP = 3'd1,
		REG_SIGNAL_PEAK  = 3'd2,
		REG_MODULATE     = 3'd3,
		REG_OUTPUT_GAIN  = 3'd4
	} cfg_reg_t;

	localparam logic [CODE_RATE_W-1:0] CODE_RATE_RST    = 33'h1_0000_0000;
	localparam logic [31:0]            CARRIER_STEP_RST = 32'd756987680;
	localparam logic [15:0]            SIGNAL_PEAK_RST  = 16'd2185;
	localparam logic                   MODULATE_RST     = 1'b0;
	localparam logic [3:0]             OUTPUT_GAIN_RST  = 4'd5;

	// Spreading codes, bit i is chip i of the reversed code
	localparam logic [127:0] INNER_CODE = 128'hF36985D6F610E778_BA1F5022913D7950;
	localparam logic [127:0] OUTER_CODE = 128'hE122213F996F21B1_6A9697DBEA898D98;

	// Queue between front and back (depth is a power of two)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Datapath widths
	localparam int V_W     = 21;   // +-peak plus 16*noise
	localparam int SINE_W  = 17;   // Q1.15 sine, holds +2^15 too
	localparam int PROD_W  = V_W + SINE_W;
	localparam int GPROD_W = PROD_W + 4;

	localparam logic signed [SINE_W-1:0] SINE_ONE = 17'sh08000;

	typedef struct packed {
		logic signed [15:0]         noise;
		logic [CODE_BITS-1:0]       code_idx;
		logic [SINE_ADDR_BITS-1:0]  sine_addr;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Quarter-wave sine table, Q30 series to x^13 evaluated at elaboration
	typedef logic [14:0] qtr_tab_t [QTR_SIZE];

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam logic [63:0] SER_D6      = 64'd156;
	localparam logic [63:0] SER_D5      = 64'd110;
	localparam logic [63:0] SER_D4      = 64'd72;
	localparam logic [63:0] SER_D3      = 64'd42;
	localparam logic [63:0] SER_D2      = 64'd20;
	localparam logic [63:0] SER_D1      = 64'd6;

	function automatic qtr_tab_t build_qtr();
		qtr_tab_t    tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k < QTR_SIZE; k++) begin
			x  = (64'(2 * k + 1) * Q30_HALF_PI) >> (QTR_BITS + 1);
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			t  = Q30_ONE - ((x2 * t) >> 30) / SER_D6;
			t  = Q30_ONE - ((x2 * t) >> 30) / SER_D5;
			t  = Q30_ONE - ((x2 * t) >> 30) / SER_D4;
			t  = Q30_ONE - ((x2 * t) >> 30) / SER_D3;
			t  = Q30_ONE - ((x2 * t) >> 30) / SER_D2;
			t  = Q30_ONE - ((x2 * t) >> 30) / SER_D1;
			s  = (x * t) >> 30;
			s  = (s + (64'd1 << 14)) >> 15;
			if (s > 64'd32767)
				s = 64'd32767;
			tab[k] = s[14:0];
		end
		return tab;
	endfunction

	localparam qtr_tab_t QTR_SINE = build_qtr();

endpackage

`default_nettype wire

// ===== rtl/core/dcsg_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dcsg_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] noise_sample;

	modport source (output valid, output noise_sample, input ready);
	modport sink (input valid, input noise_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dcsg_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dcsg_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] sample;
	logic              chip_bit;
	logic              clipped;

	modport source (output valid, output sample, output chip_bit, output clipped, input ready);
	modport sink (input valid, input sample, input chip_bit, input clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dcsg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcsg_front (
	input  logic                              clk,
	input  logic                              arst_n,
	dcsg_in_if.sink                           noise_in,
	input  logic [dcsg_pkg::CODE_RATE_W-1:0]  code_rate,
	input  logic [dcsg_pkg::CARRIER_W-1:0]    carrier_step,
	input  logic                              q_full,
	output dcsg_pkg::q_push_t                 push
);
	import dcsg_pkg::*;

	logic [PH_W-1:0]      code_phase_q;
	logic [CARRIER_W-1:0] carrier_phase_q;
	logic [PH_W-1:0]      code_step;
	logic [PH_W-1:0]      code_next;
	logic [CARRIER_W-1:0] carrier_next;
	logic                 accept;

	assign noise_in.ready = !q_full;
	assign accept         = noise_in.valid && !q_full;

	// Align the rate to the phase fraction
	always_comb begin
		if (PHASE_BITS >= 32)
			code_step = PH_W'(code_rate) << RATE_SHL;
		else
			code_step = PH_W'(code_rate >> RATE_SHR);
	end

	assign code_next    = code_phase_q + code_step;
	assign carrier_next = carrier_phase_q + carrier_step;

	// Request into the queue: updated phases select chip and sine entry
	always_comb begin
		push.valid          = accept;
		push.item.noise     = noise_in.noise_sample;
		push.item.code_idx  = code_next[PH_W-1 -: CODE_BITS];
		push.item.sine_addr = carrier_next[CARRIER_W-1 -: SINE_ADDR_BITS];
	end

	// Phase accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_phase_q    <= '0;
			carrier_phase_q <= '0;
		end else if (accept) begin
			code_phase_q    <= code_next;
			carrier_phase_q <= carrier_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dcsg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcsg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  dcsg_pkg::q_push_t push,
	input  logic              pop,
	output dcsg_pkg::item_t   head,
	output dcsg_pkg::q_stat_t stat
);
	import dcsg_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push.valid && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push.valid && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dcsg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcsg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dcsg_pkg::item_t   head,
	input  dcsg_pkg::q_stat_t qstat,
	output logic              pop,
	input  logic [15:0]       signal_peak,
	input  logic              modulate_enable,
	input  logic [3:0]        output_gain,
	dcsg_out_if.source        sample_out
);
	import dcsg_pkg::*;

	// Pipeline control
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic adv;

	// Stage 1 inputs and registers
	logic                      chip_c;
	logic [QTR_BITS-1:0]       qtr_idx;
	logic signed [SINE_W-1:0]  sine_c;
	logic signed [V_W-1:0]     peak_c;
	logic signed [V_W-1:0]     v_c;
	logic signed [V_W-1:0]     v_s1;
	logic signed [SINE_W-1:0]  sine_s1;
	logic                      chip_s1;

	// Stage 2 and 3
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      chip_s2;
	logic signed [GPROD_W-1:0] gprod_c;
	logic signed [GPROD_W-1:0] gprod_s3;
	logic                      chip_s3;

	// Rounding and saturation
	logic                      neg_c;
	logic [GPROD_W-1:0]        abs_c;
	logic [GPROD_W-1:0]        rnd_c;
	logic [GPROD_W-32:0]       mag_c;
	logic                      clip_c;
	logic signed [7:0]         res_c;

	logic signed [7:0]         sample_q;
	logic                      chip_q;
	logic                      clip_q;

	assign adv = !out_valid_q || sample_out.ready;
	assign pop = adv && !qstat.empty;

	// Chip lookup, chip value plus noise, sine table read
	always_comb begin
		chip_c  = INNER_CODE[head.code_idx[CODE_BITS-1 -: 7]] ^ ~OUTER_CODE[head.code_idx[6:0]];
		peak_c  = $signed({{(V_W - 16){1'b0}}, signal_peak});
		v_c     = (chip_c ? peak_c : -peak_c)
			+ $signed({{(V_W - 20){head.noise[15]}}, head.noise, 4'b0000});
		qtr_idx = head.sine_addr[QTR_BITS-1:0];
		if (head.sine_addr[QTR_BITS])
			qtr_idx = ~qtr_idx;
		sine_c  = $signed({2'b00, QTR_SINE[qtr_idx]});
		if (head.sine_addr[QTR_BITS+1])
			sine_c = -sine_c;
		if (!modulate_enable)
			sine_c = SINE_ONE;
	end

	assign gprod_c = prod_s2 * $signed({1'b0, output_gain});

	// Round half away from zero, then clamp to a signed byte
	always_comb begin
		neg_c = gprod_s3[GPROD_W-1];
		abs_c = neg_c ? GPROD_W'(-gprod_s3) : GPROD_W'(gprod_s3);
		rnd_c = abs_c + (GPROD_W'(1) << 30);
		mag_c = rnd_c[GPROD_W-1:31];
		if (neg_c) begin
			clip_c = mag_c > (GPROD_W - 31)'(128);
			res_c  = clip_c ? -8'sd128 : $signed(8'(8'd0 - mag_c[7:0]));
		end else begin
			clip_c = mag_c > (GPROD_W - 31)'(127);
			res_c  = clip_c ? 8'sd127 : $signed(mag_c[7:0]);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !qstat.empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1     <= v_c;
			sine_s1  <= sine_c;
			chip_s1  <= chip_c;
			prod_s2  <= v_s1 * sine_s1;
			chip_s2  <= chip_s1;
			gprod_s3 <= gprod_c;
			chip_s3  <= chip_s2;
			sample_q <= res_c;
			chip_q   <= chip_s3;
			clip_q   <= clip_c;
		end
	end

	assign sample_out.valid    = out_valid_q;
	assign sample_out.sample   = sample_q;
	assign sample_out.chip_bit = chip_q;
	assign sample_out.clipped  = clip_q;

endmodule

`default_nettype wire

// ===== rtl/core/dsss_chip_signal_generator.sv =====
// Pipeline: an accepted request passes through the queue write, the table/chip stage,
// two multiply stages and the output register.
// Throughput: one request per cycle while the queue is not full; the 4-entry queue
// and the output register let the input and output stall independently.
// Reset: async active-low; phases clear to zero, registers take defaults,
// the sine table is constant and needs no fill.
`timescale 1ns / 1ps
`default_nettype none

module dsss_chip_signal_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcsg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	dcsg_in_if.sink                          noise_in,
	dcsg_out_if.source                       sample_out
);
	import dcsg_pkg::*;

	logic [CODE_RATE_W-1:0] code_rate_q;
	logic [CARRIER_W-1:0]   carrier_step_q;
	logic [15:0]            signal_peak_q;
	logic                   modulate_q;
	logic [3:0]             gain_q;

	q_push_t push;
	q_stat_t qstat;
	item_t   head;
	logic    pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_rate_q    <= CODE_RATE_RST;
			carrier_step_q <= CARRIER_STEP_RST;
			signal_peak_q  <= SIGNAL_PEAK_RST;
			modulate_q     <= MODULATE_RST;
			gain_q         <= OUTPUT_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODE_RATE:    code_rate_q    <= cfg_wdata[CODE_RATE_W-1:0];
				REG_CARRIER_STEP: carrier_step_q <= cfg_wdata[CARRIER_W-1:0];
				REG_SIGNAL_PEAK:  signal_peak_q  <= cfg_wdata[15:0];
				REG_MODULATE:     modulate_q     <= cfg_wdata[0];
				REG_OUTPUT_GAIN:  gain_q         <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	dcsg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.noise_in     (noise_in),
		.code_rate    (code_rate_q),
		.carrier_step (carrier_step_q),
		.q_full       (qstat.full),
		.push         (push)
	);

	dcsg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	dcsg_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.qstat           (qstat),
		.pop             (pop),
		.signal_peak     (signal_peak_q),
		.modulate_enable (modulate_q),
		.output_gain     (gain_q),
		.sample_out      (sample_out)
	);

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		sample_out.valid && sample_out.clipped |->
			sample_out.sample == 8'sd127 || sample_out.sample == -8'sd128)
		else $error("clipped sample not at a rail");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		sample_out.valid && gain_q == 4'd0 |->
			sample_out.sample == 8'sd0 && !sample_out.clipped)
		else $error("nonzero sample with zero gain");
`endif

endmodule

`default_nettype wire

// ===== tb/dsss_chip_signal_generator_test.sv =====
`timescale 1ns / 1ps

module dsss_chip_signal_generator_test;
	import dcsg_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES  = 200;
	localparam int LIMIT_CYCLES = 1_000_000;

	// Spreading codes, bit i is chip i of the reversed code
	localparam logic [127:0] INNER_CHIPS = 128'hF36985D6F610E778_BA1F5022913D7950;
	localparam logic [127:0] OUTER_CHIPS = 128'hE122213F996F21B1_6A9697DBEA898D98;

	// first of the indexes that map to no register
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG_BASE = 3'd5;

	typedef struct packed {
		logic signed [7:0] sample;
		logic              chip_bit;
		logic              clipped;
	} chip_sample_t;

	typedef struct packed {
		logic [32:0] rate;
		logic [31:0] step;
		logic [15:0] peak;
		logic        modulate;
		logic [3:0]  gain;
	} gen_settings_t;

	// Predicts each output sample and holds the ones still owed by the block
	class chip_sample_predictor;
		logic [32:0]       code_rate;
		logic [31:0]       carrier_step;
		logic [15:0]       signal_peak;
		logic              modulate;
		logic [3:0]        gain;
		logic [PH_W-1:0]   code_phase;
		logic [31:0]       carrier_phase;
		logic [14:0]       quarter_sine [QTR_SIZE];
		chip_sample_t      expected_samples [$];
		int                mismatches;

		function new();
			logic [63:0] x;
			logic [63:0] x2;
			logic [63:0] t;
			logic [63:0] s;
			code_rate     = 33'h1_0000_0000;
			carrier_step  = 32'd756987680;
			signal_peak   = 16'd2185;
			modulate      = 1'b0;
			gain          = 4'd5;
			code_phase    = '0;
			carrier_phase = '0;
			mismatches    = 0;
			// quarter sine, Q30 Horner series up to x^13, sampled at bin centers
			for (int k = 0; k < QTR_SIZE; k++) begin
				x  = (64'(2 * k + 1) * 64'd1686629713) >> (QTR_BITS + 1);
				x2 = (x * x) >> 30;
				t  = 64'd1 << 30;
				for (int n = 6; n >= 1; n--)
					t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(2 * n * (2 * n + 1));
				s = (x * t) >> 30;
				s = (s + (64'd1 << 14)) >> 15;
				if (s > 64'd32767)
					s = 64'd32767;
				quarter_sine[k] = s[14:0];
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_CODE_RATE:    code_rate    = data[32:0];
				REG_CARRIER_STEP: carrier_step = data[31:0];
				REG_SIGNAL_PEAK:  signal_peak  = data[15:0];
				REG_MODULATE:     modulate     = data[0];
				REG_OUTPUT_GAIN:  gain         = data[3:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		// advance both phases, then build the sample from the updated values
		function void note_noise(logic signed [15:0] noise);
			logic [63:0]               step;
			logic [CODE_BITS-1:0]      chip_idx;
			logic [SINE_ADDR_BITS-1:0] addr;
			logic [QTR_BITS-1:0]       k;
			logic                      chip;
			longint                    wave;
			longint                    v;
			longint                    p;
			longint                    r;
			logic [63:0]               mag;
			chip_sample_t              res;

			step = 64'(code_rate);
			if (PHASE_BITS >= 32)
				step = step << (PHASE_BITS - 32);
			else
				step = step >> (32 - PHASE_BITS);
			code_phase    = code_phase + PH_W'(step);
			carrier_phase = carrier_phase + carrier_step;

			chip_idx = code_phase[PH_W-1 -: CODE_BITS];
			chip = INNER_CHIPS[chip_idx[CODE_BITS-1 -: 7]] ^ ~OUTER_CHIPS[chip_idx[6:0]];

			// quadrant lookup: odd quadrants mirror, upper half negates
			addr = carrier_phase[31 -: SINE_ADDR_BITS];
			k = addr[QTR_BITS-1:0];
			if (addr[SINE_ADDR_BITS-2])
				k = ~k;
			wave = longint'(quarter_sine[k]);
			if (addr[SINE_ADDR_BITS-1])
				wave = -wave;

			v = chip ? longint'(signal_peak) : -longint'(signal_peak);
			v = v + 16 * longint'(noise);
			p = modulate ? v * wave : v * 32768;
			p = p * longint'(gain);

			// round half away from zero at 2^-31
			mag = (p < 0) ? 64'(-p) : 64'(p);
			mag = (mag + (64'd1 << 30)) >> 31;
			r = (p < 0) ? -longint'(mag) : longint'(mag);

			res.clipped = 1'b0;
			if (r > 127) begin
				r = 127;
				res.clipped = 1'b1;
			end
			if (r < -128) begin
				r = -128;
				res.clipped = 1'b1;
			end
			res.sample   = 8'(r);
			res.chip_bit = chip;
			expected_samples.push_back(res);
		endfunction

		function void check_sample(logic signed [7:0] sample, logic chip_bit, logic clipped);
			chip_sample_t want;
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result, sample %0d chip %0b clipped %0b",
					$time, sample, chip_bit, clipped);
				mismatches++;
				return;
			end
			want = expected_samples.pop_front();
			if (sample !== want.sample) begin
				$display("%0t: sample mismatch, expected %0d, got %0d", $time, want.sample, sample);
				mismatches++;
			end
			if (chip_bit !== want.chip_bit) begin
				$display("%0t: chip_bit mismatch, expected %0b, got %0b",
					$time, want.chip_bit, chip_bit);
				mismatches++;
			end
			if (clipped !== want.clipped) begin
				$display("%0t: clipped mismatch, expected %0b, got %0b",
					$time, want.clipped, clipped);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  rx_ready = 1'b0;
	logic                  rx_hold = 1'b0;
	int                    tx_idle_pct = 0;
	int                    rx_stall_pct = 0;
	int                    tx_idle_sets [4] = '{0, 56, 0, 25};
	int                    rx_stall_sets [4] = '{0, 0, 56, 25};
	event                  hold_start;
	chip_sample_predictor  sample_board;

	dcsg_in_if  noise_in ();
	dcsg_out_if sample_out ();

	assign sample_out.ready = rx_ready;

	dsss_chip_signal_generator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.noise_in   (noise_in),
		.sample_out (sample_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result side: check accepted samples, randomize ready
	always @(posedge clk) begin
		if (arst_n && sample_out.valid && rx_ready)
			sample_board.check_sample(sample_out.sample, sample_out.chip_bit, sample_out.clipped);
		rx_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Long receiver hold-off, counted here
	initial begin
		forever begin
			@(hold_start);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// Run limit
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_noise(input logic signed [15:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			noise_in.valid <= 1'b0;
			@(posedge clk);
		end
		noise_in.valid        <= 1'b1;
		noise_in.noise_sample <= value;
		do
			@(posedge clk);
		while (!noise_in.ready);
		sample_board.note_noise(value);
	endtask

	function automatic logic signed [15:0] random_noise();
		if ($urandom_range(1))
			return 16'($urandom());
		return 16'($urandom_range(4095)) - 16'sd2048;
	endfunction

	task automatic send_random_noise(input int count);
		for (int i = 0; i < count; i++)
			send_noise(random_noise());
	endtask

	// stop offering and wait for every owed sample
	task automatic quiesce();
		noise_in.valid <= 1'b0;
		while (sample_board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		sample_board.write_reg(index, data);
	endtask

	// all five registers plus one stray write to an unmapped index
	task automatic apply_settings(input gen_settings_t s);
		quiesce();
		put_reg(REG_CODE_RATE, s.rate);
		put_reg(REG_CARRIER_STEP, 33'(s.step));
		put_reg(REG_SIGNAL_PEAK, 33'(s.peak));
		put_reg(REG_MODULATE, 33'(s.modulate));
		put_reg(REG_OUTPUT_GAIN, 33'(s.gain));
		put_reg(UNUSED_REG_BASE + 3'($urandom_range(2)), {1'($urandom()), 32'($urandom())});
		cfg_we <= 1'b0;
	endtask

	function automatic gen_settings_t random_settings();
		gen_settings_t s;
		case ($urandom_range(3))
			0:       s.rate = '0;
			1:       s.rate = 33'h1_0000_0000;
			2:       s.rate = '1;
			default: s.rate = {1'($urandom()), 32'($urandom())};
		endcase
		case ($urandom_range(3))
			0:       s.step = '0;
			1:       s.step = '1;
			default: s.step = 32'($urandom());
		endcase
		case ($urandom_range(3))
			0:       s.peak = '0;
			1:       s.peak = '1;
			2:       s.peak = 16'($urandom_range(4095));
			default: s.peak = 16'($urandom());
		endcase
		s.modulate = 1'($urandom());
		s.gain     = 4'($urandom_range(15));
		return s;
	endfunction

	initial begin
		sample_board = new();
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= REG_CODE_RATE;
		cfg_wdata             <= '0;
		noise_in.valid        <= 1'b0;
		noise_in.noise_sample <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: noise extremes and alternating bit patterns
		send_noise(16'sd0);
		send_noise(16'sd32767);
		send_noise(-16'sd32768);
		send_noise(-16'sd1);
		send_noise(16'sd1);
		send_noise(16'sh5555);
		send_noise(16'shAAAA);

		// frozen code phase, full peak and gain: saturation both ways
		apply_settings('{rate: '0, step: '0, peak: '1, modulate: 1'b0, gain: 4'd15});
		send_noise(16'sd32767);
		send_noise(-16'sd32768);
		send_noise(16'sd0);

		// quarter-turn carrier steps land in every sine quadrant
		apply_settings('{rate: '1, step: 32'h4000_0000, peak: '1, modulate: 1'b1, gain: 4'd15});
		send_noise(16'sd32767);
		send_noise(16'sd32767);
		send_noise(16'sd32767);
		send_noise(16'sd32767);
		send_noise(-16'sd32768);

		// zero gain always gives zero, never clipped
		apply_settings('{rate: 33'h1_0000_0000, step: '1, peak: '0, modulate: 1'b1, gain: 4'd0});
		send_noise(16'sd32767);
		send_noise(-16'sd32768);

		// exact half-LSB values round away from zero
		apply_settings('{rate: 33'h0_8000_0000, step: 32'd12345678, peak: '0,
			modulate: 1'b0, gain: 4'd1});
		send_noise(16'sd2048);
		send_noise(-16'sd2048);
		send_noise(16'sd6144);
		send_noise(-16'sd6144);

		// back-pressure: receiver held off while requests keep coming
		apply_settings(random_settings());
		-> hold_start;
		send_random_noise(48);
		quiesce();

		// near two chips per sample: the code index skips about every other chip
		apply_settings('{rate: '1, step: 32'($urandom()), peak: 16'($urandom()),
			modulate: 1'b1, gain: 4'($urandom_range(15))});
		send_random_noise(100);

		// random settings under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			for (int seg = 0; seg < 4; seg++) begin
				apply_settings(random_settings());
				tx_idle_pct  = tx_idle_sets[ph];
				rx_stall_pct = rx_stall_sets[ph];
				send_random_noise(90);
			end
		end

		quiesce();
		repeat (10) @(posedge clk);
		if (sample_board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/dcsg_pkg.sv
rtl/core/dcsg_in_if.sv
rtl/core/dcsg_out_if.sv
rtl/core/dcsg_front.sv
rtl/core/dcsg_queue.sv
rtl/core/dcsg_back.sv
rtl/core/dsss_chip_signal_generator.sv
tb/dsss_chip_signal_generator_test.sv
